// ===== rtl/ysr_pkg.sv =====
// ----------------------------------------------------------------------------
// ysr_pkg
// Shared sizes, payload types and the pixel color conversion for the
// YUYV to RGB nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package ysr_pkg;

  // frame geometry
  localparam int SRC_WIDTH  = 640;
  localparam int SRC_HEIGHT = 480;
  localparam int DST_WIDTH  = 720;
  localparam int DST_HEIGHT = 406;

  localparam int SRC_PAIRS = SRC_WIDTH / 2;

  // per-step increments of the mapping accumulators
  localparam int COL_Q = DST_WIDTH / SRC_WIDTH;
  localparam int COL_R = DST_WIDTH % SRC_WIDTH;
  localparam int ROW_Q = DST_HEIGHT / SRC_HEIGHT;
  localparam int ROW_R = DST_HEIGHT % SRC_HEIGHT;

  // output pair index must stay below this to keep 2*pair < DST_WIDTH
  localparam int PAIR_LIMIT = (DST_WIDTH + 1) / 2;

  // counter and accumulator widths
  localparam int COL_W = (SRC_PAIRS > 1) ? $clog2(SRC_PAIRS) : 1;
  localparam int ROW_W = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int K_W   = $clog2(DST_WIDTH + 1);
  localparam int DY_W  = $clog2(DST_HEIGHT + 1);
  localparam int T_W   = $clog2(SRC_WIDTH);
  localparam int S_W   = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int XW    = $clog2(SRC_WIDTH + DST_WIDTH + 1) + 1;
  localparam int YW    = $clog2(SRC_HEIGHT + DST_HEIGHT + 1) + 1;

  // result field widths
  localparam int DEST_X_W = 10;
  localparam int DEST_Y_W = 9;

  // job queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_start;
  } ysr_in_t;

  typedef struct packed {
    logic [DEST_X_W-1:0] dest_x;
    logic [DEST_Y_W-1:0] dest_y;
    logic [7:0]          red_left;
    logic [7:0]          green_left;
    logic [7:0]          blue_left;
    logic [7:0]          red_right;
    logic [7:0]          green_right;
    logic [7:0]          blue_right;
    logic                last_of_run;
  } ysr_out_t;

  // one classified macropixel waiting for conversion
  typedef struct packed {
    logic [7:0]      luma_first;
    logic [7:0]      chroma_blue;
    logic [7:0]      luma_second;
    logic [7:0]      chroma_red;
    logic [K_W-1:0]  pair;
    logic [DY_W-1:0] line;
    logic            two;
  } ysr_job_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ysr_rgb_t;

  // clamp a shifted channel value to 0..255
  function automatic logic [7:0] ysr_clamp8(input logic signed [19:0] v);
    logic [7:0] res;
    if (v[19]) begin
      res = 8'd0;
    end else if (|v[18:8]) begin
      res = 8'hff;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // integer bt.601 conversion of one pixel
  function automatic ysr_rgb_t ysr_convert(input logic [7:0] y, input logic [7:0] u,
                                           input logic [7:0] v);
    logic signed [19:0] c;
    logic signed [19:0] d;
    logic signed [19:0] e;
    logic signed [19:0] r;
    logic signed [19:0] g;
    logic signed [19:0] b;
    ysr_rgb_t           px;
    c = $signed({12'd0, y}) - 20'sd16;
    d = $signed({12'd0, u}) - 20'sd128;
    e = $signed({12'd0, v}) - 20'sd128;
    r = 20'sd298 * c + 20'sd409 * e + 20'sd128;
    g = 20'sd298 * c - 20'sd100 * d - 20'sd208 * e + 20'sd128;
    b = 20'sd298 * c + 20'sd516 * d + 20'sd128;
    px.red   = ysr_clamp8(r >>> 8);
    px.green = ysr_clamp8(g >>> 8);
    px.blue  = ysr_clamp8(b >>> 8);
    return px;
  endfunction

endpackage

// ===== rtl/yuyv_scale_to_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// yuyv_scale_to_rgb_unit
// Nearest-neighbor scaler from packed YUYV macropixels to RGB pixel pairs.
// ----------------------------------------------------------------------------
//  side     handshake          word             accepted when
//  input    push / full        in_data_i        push && !full
//  result   empty / pop        out_data_o       pop && !empty
//
//  one result word per cycle while pop is held; a macropixel with two
//  output pairs holds the output register for both words, so the result
//  port sets the rate; words pass the job queue, then the output register
//  macropixels with no output pair are absorbed without a queue entry
//  reset clears the position counters, the job queue and output valid
//  a four-entry job queue lets input keep flowing while results stall
// ----------------------------------------------------------------------------
module yuyv_scale_to_rgb_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ysr_pkg::ysr_in_t  in_data_i,
  output logic              empty,
  input  logic              pop,
  output ysr_pkg::ysr_out_t out_data_o
);

  logic              job_push;
  ysr_pkg::ysr_job_t job;
  ysr_pkg::ysr_job_t head;
  logic              head_empty;
  logic              head_pop;

  // front: position tracking and classification
  ysr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_data_i   (in_data_i),
    .fifo_full_i (full),
    .job_push_o  (job_push),
    .job_o       (job)
  );

  // job queue
  ysr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job),
    .pop_i   (head_pop),
    .head_o  (head),
    .empty_o (head_empty),
    .full_o  (full)
  );

  // back: conversion and result issue
  ysr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (~head_empty),
    .head_pop_o   (head_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== rtl/ysr_front.sv =====
// ----------------------------------------------------------------------------
// ysr_front
// Accepts macropixels, tracks source position and the matching output
// row and pair, and queues the macropixels that produce results.
// ----------------------------------------------------------------------------
module ysr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ysr_pkg::ysr_in_t  in_data_i,
  input  logic              fifo_full_i,
  output logic              job_push_o,
  output ysr_pkg::ysr_job_t job_o
);

  localparam int CW = ysr_pkg::COL_W + 1;
  localparam int RW = ysr_pkg::ROW_W + 1;
  localparam int XW = ysr_pkg::XW;
  localparam int YW = ysr_pkg::YW;

  logic                      accept;

  logic [ysr_pkg::COL_W-1:0] col_q, col_d, col_b;
  logic [ysr_pkg::ROW_W-1:0] row_q, row_d, row_b;
  logic [ysr_pkg::K_W-1:0]   pair_q, pair_d, pair_b;
  logic [ysr_pkg::T_W-1:0]   slack_x_q, slack_x_d, slack_x_b;
  logic [ysr_pkg::DY_W-1:0]  line_q, line_d, line_b;
  logic [ysr_pkg::S_W-1:0]   slack_y_q, slack_y_d, slack_y_b;

  logic                      row_used;
  logic                      first_hit;
  logic                      second_hit;
  logic [CW-1:0]             col_inc;
  logic [RW-1:0]             row_inc;
  logic signed [XW-1:0]      tx_adj;
  logic signed [YW-1:0]      ty_adj;

  assign accept = push_i & ~fifo_full_i;

  // frame start restarts the position before the word is used
  always_comb begin
    if (in_data_i.frame_start) begin
      col_b     = '0;
      row_b     = '0;
      pair_b    = '0;
      slack_x_b = '0;
      line_b    = '0;
      slack_y_b = '0;
    end else begin
      col_b     = col_q;
      row_b     = row_q;
      pair_b    = pair_q;
      slack_x_b = slack_x_q;
      line_b    = line_q;
      slack_y_b = slack_y_q;
    end
  end

  // classify: row in use, and how many output pairs map onto this pair
  always_comb begin
    row_used   = (YW'(line_b) < YW'(ysr_pkg::DST_HEIGHT)) &&
                 (YW'(slack_y_b) < YW'(ysr_pkg::DST_HEIGHT));
    first_hit  = row_used &&
                 (XW'(pair_b) < XW'(ysr_pkg::PAIR_LIMIT)) &&
                 (XW'(slack_x_b) < XW'(ysr_pkg::DST_WIDTH));
    second_hit = first_hit &&
                 ((XW'(pair_b) + XW'(1)) < XW'(ysr_pkg::PAIR_LIMIT)) &&
                 ((XW'(slack_x_b) + XW'(ysr_pkg::SRC_WIDTH)) < XW'(ysr_pkg::DST_WIDTH));
  end

  assign job_push_o        = accept & first_hit;
  assign job_o.luma_first  = in_data_i.luma_first;
  assign job_o.chroma_blue = in_data_i.chroma_blue;
  assign job_o.luma_second = in_data_i.luma_second;
  assign job_o.chroma_red  = in_data_i.chroma_red;
  assign job_o.pair        = pair_b;
  assign job_o.line        = line_b;
  assign job_o.two         = second_hit;

  // position advance with incremental nearest-neighbor mapping
  always_comb begin
    col_inc   = CW'(col_b) + CW'(1);
    row_inc   = RW'(row_b) + RW'(1);
    tx_adj    = $signed(XW'(slack_x_b)) - $signed(XW'(ysr_pkg::COL_R));
    ty_adj    = $signed(YW'(slack_y_b)) - $signed(YW'(ysr_pkg::ROW_R));
    col_d     = col_b;
    row_d     = row_b;
    pair_d    = pair_b;
    slack_x_d = slack_x_b;
    line_d    = line_b;
    slack_y_d = slack_y_b;
    if (col_inc >= CW'(ysr_pkg::SRC_PAIRS)) begin
      col_d     = '0;
      pair_d    = '0;
      slack_x_d = '0;
      if (row_inc >= RW'(ysr_pkg::SRC_HEIGHT)) begin
        row_d     = '0;
        line_d    = '0;
        slack_y_d = '0;
      end else begin
        row_d = ysr_pkg::ROW_W'(row_inc);
        if (ty_adj[YW-1]) begin
          line_d    = line_b + ysr_pkg::DY_W'(ysr_pkg::ROW_Q + 1);
          slack_y_d = ysr_pkg::S_W'(ty_adj + YW'(ysr_pkg::SRC_HEIGHT));
        end else begin
          line_d    = line_b + ysr_pkg::DY_W'(ysr_pkg::ROW_Q);
          slack_y_d = ysr_pkg::S_W'(ty_adj);
        end
      end
    end else begin
      col_d = ysr_pkg::COL_W'(col_inc);
      if (tx_adj[XW-1]) begin
        pair_d    = pair_b + ysr_pkg::K_W'(ysr_pkg::COL_Q + 1);
        slack_x_d = ysr_pkg::T_W'(tx_adj + XW'(ysr_pkg::SRC_WIDTH));
      end else begin
        pair_d    = pair_b + ysr_pkg::K_W'(ysr_pkg::COL_Q);
        slack_x_d = ysr_pkg::T_W'(tx_adj);
      end
    end
  end

  // position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      pair_q    <= '0;
      slack_x_q <= '0;
      line_q    <= '0;
      slack_y_q <= '0;
    end else if (accept) begin
      col_q     <= col_d;
      row_q     <= row_d;
      pair_q    <= pair_d;
      slack_x_q <= slack_x_d;
      line_q    <= line_d;
      slack_y_q <= slack_y_d;
    end
  end

endmodule

// ===== rtl/ysr_fifo.sv =====
// ----------------------------------------------------------------------------
// ysr_fifo
// Short job queue that decouples the classifying front from the
// converting back.
// ----------------------------------------------------------------------------
module ysr_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ysr_pkg::ysr_job_t job_i,
  input  logic              pop_i,
  output ysr_pkg::ysr_job_t head_o,
  output logic              empty_o,
  output logic              full_o
);

  ysr_pkg::ysr_job_t              mem_q [ysr_pkg::FIFO_DEPTH];
  logic [ysr_pkg::FIFO_AW-1:0]    wptr_q, wptr_d;
  logic [ysr_pkg::FIFO_AW-1:0]    rptr_q, rptr_d;
  logic [ysr_pkg::FIFO_CW-1:0]    cnt_q, cnt_d;
  logic                           do_push;
  logic                           do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == ysr_pkg::FIFO_CW'(ysr_pkg::FIFO_DEPTH));
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == ysr_pkg::FIFO_AW'(ysr_pkg::FIFO_DEPTH - 1)) ? '0 :
               wptr_q + ysr_pkg::FIFO_AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == ysr_pkg::FIFO_AW'(ysr_pkg::FIFO_DEPTH - 1)) ? '0 :
               rptr_q + ysr_pkg::FIFO_AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + ysr_pkg::FIFO_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - ysr_pkg::FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/ysr_back.sv =====
// ----------------------------------------------------------------------------
// ysr_back
// Takes queued jobs, converts the pixel pair to RGB and issues one or
// two result words through the output register.
// ----------------------------------------------------------------------------
module ysr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ysr_pkg::ysr_job_t head_i,
  input  logic              head_valid_i,
  output logic              head_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ysr_pkg::ysr_out_t out_data_o
);

  logic                    sub_q, sub_d;
  logic                    out_valid_q, out_valid_d;
  ysr_pkg::ysr_out_t       out_q, out_d;
  logic                    load;
  logic                    last;
  logic [ysr_pkg::K_W-1:0] pair_sel;
  ysr_pkg::ysr_rgb_t       px_left;
  ysr_pkg::ysr_rgb_t       px_right;

  assign empty_o    = ~out_valid_q;
  assign out_data_o = out_q;

  // output register takes a new word when free or being drained
  assign load       = head_valid_i & (~out_valid_q | pop_i);
  assign last       = ~head_i.two | sub_q;
  assign head_pop_o = load & last;

  // color conversion of the head job
  assign px_left  = ysr_pkg::ysr_convert(head_i.luma_first, head_i.chroma_blue,
                                         head_i.chroma_red);
  assign px_right = ysr_pkg::ysr_convert(head_i.luma_second, head_i.chroma_blue,
                                         head_i.chroma_red);
  assign pair_sel = head_i.pair + ysr_pkg::K_W'(sub_q);

  // result word assembly
  always_comb begin
    out_d.dest_x      = ysr_pkg::DEST_X_W'({pair_sel, 1'b0});
    out_d.dest_y      = ysr_pkg::DEST_Y_W'(head_i.line);
    out_d.red_left    = px_left.red;
    out_d.green_left  = px_left.green;
    out_d.blue_left   = px_left.blue;
    out_d.red_right   = px_right.red;
    out_d.green_right = px_right.green;
    out_d.blue_right  = px_right.blue;
    out_d.last_of_run = last;
  end

  // pair sequencing and output valid
  always_comb begin
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    if (load) begin
      sub_d       = ~last;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== rtl/ysr_checker.sv =====
// ----------------------------------------------------------------------------
// ysr_checker
// Port-level checks of the scaler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ysr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input ysr_pkg::ysr_out_t out_data_o
);

  // a waiting result word holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
  else $error("result word changed while stalled");

  // the first pair of a macropixel is followed at once by its partner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_data_o.last_of_run) |=>
      (!empty &&
       out_data_o.dest_x == ysr_pkg::DEST_X_W'($past(out_data_o.dest_x) + 2'd2) &&
       out_data_o.dest_y == $past(out_data_o.dest_y) &&
       out_data_o.red_left == $past(out_data_o.red_left) &&
       out_data_o.blue_right == $past(out_data_o.blue_right)))
  else $error("second pair of a macropixel missing or inconsistent");

  // the queue only fills through accepted input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
  else $error("full rose without a push");

  // output pairs start on even columns
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !out_data_o.dest_x[0])
  else $error("odd dest_x on a result word");

endmodule

bind yuyv_scale_to_rgb_unit ysr_checker u_ysr_checker (.*);
